[rtl/dic_pkg.sv]
// Shared types, constants and helper functions for the decoded instruction cache.
// Depends on nothing; the top level, dic_lookup and the testbench import it.
package dic_pkg;

  localparam int unsigned DEFAULT_ENTRIES = 512;
  localparam int unsigned ADDR_W          = 32;
  localparam int unsigned OPCODE_W        = 16;
  localparam int unsigned USES_W          = 8;
  localparam int unsigned CYCLES_W        = 2;
  localparam int unsigned THRESH_W        = 8;

  localparam logic [THRESH_W-1:0] HOT_THRESHOLD_RESET = 8'd20;
  localparam logic [USES_W-1:0]   USES_MAX            = 8'hFF;
  localparam logic [USES_W-1:0]   USES_FIRST          = 8'd1;

  // Top nibble codes of the opcode that set the cycle estimate.
  localparam logic [3:0] NIB_BRANCH_LIKE = 4'h2;
  localparam logic [3:0] NIB_MOVE_GROUP  = 4'h6;
  localparam logic [3:0] NIB_GROUP_8     = 4'h8;
  localparam logic [3:0] NIB_GROUP_A     = 4'hA;
  localparam logic [3:0] NIB_GROUP_B     = 4'hB;
  localparam logic [3:0] NIB_GROUP_F     = 4'hF;
  localparam logic [3:0] MOVE_SHORT_MAX  = 4'h3;

  localparam logic [CYCLES_W-1:0] CYC_ONE   = 2'd1;
  localparam logic [CYCLES_W-1:0] CYC_TWO   = 2'd2;
  localparam logic [CYCLES_W-1:0] CYC_THREE = 2'd3;

  // One result as it leaves the lookup stage.
  typedef struct packed {
    logic [OPCODE_W-1:0] instruction;
    logic [CYCLES_W-1:0] cycle_estimate;
    logic                hit;
    logic                was_hot;
    logic                address_error;
  } fetch_result_t;

  // Cycle estimate derived from the opcode's nibbles.
  function automatic logic [CYCLES_W-1:0] cycles_for(input logic [OPCODE_W-1:0] word);
    logic [CYCLES_W-1:0] est;
    est = CYC_ONE;
    unique case (word[15:12])
      NIB_MOVE_GROUP:  est = (word[3:0] <= MOVE_SHORT_MAX) ? CYC_TWO : CYC_ONE;
      NIB_BRANCH_LIKE,
      NIB_GROUP_8,
      NIB_GROUP_A,
      NIB_GROUP_B:     est = CYC_TWO;
      NIB_GROUP_F:     est = CYC_THREE;
      default:         est = CYC_ONE;
    endcase
    return est;
  endfunction

endpackage

[rtl/decoded_instruction_cache.sv]
// Top level of the decoded instruction cache: request pipeline, clearing sweep and output register.
// Depends on dic_pkg, dic_line_ram and dic_lookup.
//
// Direct-mapped cache of 16-bit instruction words. After reset the block
// clears the valid bit of every line, one line per cycle, and holds in_stall
// high meanwhile; hot_threshold writes are taken during that time as always.
// After that it accepts one fetch request per cycle while the output is not
// stalled. A request is read from the line memory at the edge that accepts
// it and is compared in the lookup stage; the line update and the result
// are written at the edge that moves it on into the output register. The
// line memory has a registered read port: each request reads its line once
// and, unless its address is odd, writes it back once, and a write that
// meets the next read of the same line is forwarded. A stalled output holds
// the request in the lookup stage and throttles the input.
// ENTRIES must be a power of two.
module decoded_instruction_cache
  import dic_pkg::*;
#(
  parameter int unsigned ENTRIES = DEFAULT_ENTRIES
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write_enable,
  input  logic [THRESH_W-1:0] cfg_write_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [ADDR_W-1:0]   fetch_address,
  input  logic [OPCODE_W-1:0] memory_word,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [OPCODE_W-1:0] instruction,
  output logic [CYCLES_W-1:0] cycle_estimate,
  output logic                hit,
  output logic                was_hot,
  output logic                address_error
);

  localparam int unsigned IDX_W  = $clog2(ENTRIES);
  localparam int unsigned TAG_W  = ADDR_W - 1 - IDX_W;
  localparam int unsigned LINE_W = 1 + TAG_W + OPCODE_W + USES_W + CYCLES_W;
  localparam logic [IDX_W-1:0] LAST_LINE = IDX_W'(ENTRIES - 1);

  // Configuration register.
  logic [THRESH_W-1:0] hot_threshold;

  // Clearing sweep after reset.
  logic             clearing;
  logic [IDX_W-1:0] clear_idx;

  // Lookup stage registers.
  logic                s1_valid;
  logic [ADDR_W-1:0]   s1_address;
  logic [OPCODE_W-1:0] s1_word;

  // Output register.
  fetch_result_t out_result;

  logic                in_accept;
  logic                s1_advance;
  logic [LINE_W-1:0]   line_rd;
  logic [LINE_W-1:0]   lookup_wr;
  logic                lookup_we;
  fetch_result_t       lookup_result;
  logic                ram_we;
  logic [IDX_W-1:0]    ram_wr_addr;
  logic [LINE_W-1:0]   ram_wr_data;

  // The lookup stage moves on when the output register is empty or being emptied.
  assign s1_advance = s1_valid && (!out_valid || !out_stall);
  assign in_stall   = clearing || (s1_valid && !s1_advance);
  assign in_accept  = in_valid && !in_stall;

  // The sweep owns the write port while it runs; no request is in flight then.
  assign ram_we      = clearing || (s1_advance && lookup_we);
  assign ram_wr_addr = clearing ? clear_idx : s1_address[IDX_W:1];
  assign ram_wr_data = clearing ? '0 : lookup_wr;

  dic_line_ram #(
    .DEPTH (ENTRIES),
    .WIDTH (LINE_W)
  ) u_line_ram (
    .clk     (clk),
    .rd_en   (in_accept),
    .rd_addr (fetch_address[IDX_W:1]),
    .rd_data (line_rd),
    .wr_en   (ram_we),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data)
  );

  dic_lookup #(
    .ENTRIES (ENTRIES),
    .IDX_W   (IDX_W),
    .TAG_W   (TAG_W),
    .LINE_W  (LINE_W)
  ) u_lookup (
    .fetch_address (s1_address),
    .memory_word   (s1_word),
    .line_rd       (line_rd),
    .hot_threshold (hot_threshold),
    .result        (lookup_result),
    .line_we       (lookup_we),
    .line_wr       (lookup_wr)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      hot_threshold <= HOT_THRESHOLD_RESET;
      clearing      <= 1'b1;
      clear_idx     <= '0;
      s1_valid      <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_write_enable) begin
        hot_threshold <= cfg_write_data;
      end
      if (clearing) begin
        clear_idx <= clear_idx + IDX_W'(1);
        if (clear_idx == LAST_LINE) begin
          clearing <= 1'b0;
        end
      end
      if (in_accept) begin
        s1_valid <= 1'b1;
      end else if (s1_advance) begin
        s1_valid <= 1'b0;
      end
      if (s1_advance) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_address <= fetch_address;
      s1_word    <= memory_word;
    end
    if (s1_advance) begin
      out_result <= lookup_result;
    end
  end

  assign instruction    = out_result.instruction;
  assign cycle_estimate = out_result.cycle_estimate;
  assign hit            = out_result.hit;
  assign was_hot        = out_result.was_hot;
  assign address_error  = out_result.address_error;

endmodule

[rtl/dic_line_ram.sv]
// Line storage of the cache: one write port, one registered read port.
// A read that meets a write to the same line in the same cycle returns the new data.
module dic_line_ram #(
  parameter int unsigned DEPTH = 512,
  parameter int unsigned WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] mem_q;
  logic [WIDTH-1:0] bypass_data;
  logic             bypass_sel;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      mem_q       <= mem[rd_addr];
      bypass_sel  <= wr_en && (wr_addr == rd_addr);
      bypass_data <= wr_data;
    end
  end

  assign rd_data = bypass_sel ? bypass_data : mem_q;

endmodule

[rtl/dic_lookup.sv]
// Tag compare, hot test and line update for one fetch request.
// Depends on dic_pkg for the result type and the cycle estimate function.
module dic_lookup
  import dic_pkg::*;
#(
  parameter int unsigned ENTRIES = DEFAULT_ENTRIES,
  parameter int unsigned IDX_W   = $clog2(ENTRIES),
  parameter int unsigned TAG_W   = ADDR_W - 1 - IDX_W,
  parameter int unsigned LINE_W  = 1 + TAG_W + OPCODE_W + USES_W + CYCLES_W
) (
  input  logic [ADDR_W-1:0]   fetch_address,
  input  logic [OPCODE_W-1:0] memory_word,
  input  logic [LINE_W-1:0]   line_rd,
  input  logic [THRESH_W-1:0] hot_threshold,
  output fetch_result_t       result,
  output logic                line_we,
  output logic [LINE_W-1:0]   line_wr
);

  logic                line_valid;
  logic [TAG_W-1:0]    line_tag;
  logic [OPCODE_W-1:0] line_opcode;
  logic [USES_W-1:0]   line_uses;
  logic [CYCLES_W-1:0] line_cycles;
  logic [TAG_W-1:0]    req_tag;
  logic                odd;
  logic                match;
  logic [CYCLES_W-1:0] est;
  logic [USES_W-1:0]   uses_next;

  assign {line_valid, line_tag, line_opcode, line_uses, line_cycles} = line_rd;

  assign req_tag   = fetch_address[ADDR_W-1:IDX_W+1];
  assign odd       = fetch_address[0];
  assign match     = line_valid && (line_tag == req_tag);
  assign est       = cycles_for(memory_word);
  assign uses_next = (line_uses == USES_MAX) ? USES_MAX : line_uses + USES_W'(1);

  always_comb begin
    result  = '0;
    line_we = 1'b0;
    line_wr = {1'b1, req_tag, memory_word, USES_FIRST, est};
    if (odd) begin
      result.address_error = 1'b1;
    end else if (match) begin
      result.instruction    = line_opcode;
      result.cycle_estimate = line_cycles;
      result.hit            = 1'b1;
      result.was_hot        = line_uses > hot_threshold;
      line_we               = 1'b1;
      line_wr               = {1'b1, line_tag, line_opcode, uses_next, line_cycles};
    end else begin
      result.instruction    = memory_word;
      result.cycle_estimate = est;
      line_we               = 1'b1;
    end
  end

endmodule

[tb/decoded_instruction_cache_tb.sv]
// Testbench for the decoded instruction cache: a directed table of fetch requests, then phases
// of random requests under several hot thresholds. Depends on dic_pkg and decoded_instruction_cache.
// Every result is checked field by field against its pinned result or else a predictor in this file.
module decoded_instruction_cache_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dic_pkg::*;

  localparam int unsigned LINES        = DEFAULT_ENTRIES;
  localparam int unsigned IDX_W        = $clog2(LINES);
  localparam int unsigned TAG_W        = ADDR_W - 1 - IDX_W;
  localparam int unsigned CYCLE_LIMIT  = 1000000;
  // Idle cycles waited after the last expected result has been taken.
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned PHASES        = 6;
  localparam int unsigned PHASE_ITEMS   = 315;
  localparam int unsigned POOL_SIZE     = 12;
  localparam int unsigned HOT_INDEXES   = 6;
  localparam int unsigned PRINT_LIMIT   = 100;

  // One row of the directed table. Pinned rows carry a result typed in by hand; the rest
  // are checked against the predictor.
  typedef struct {
    logic [ADDR_W-1:0]   addr;
    logic [OPCODE_W-1:0] word;
    bit                  pinned;
    fetch_result_t       result;
  } table_row_t;

  logic                clk              = 1'b0;
  logic                rst              = 1'b1;
  logic                cfg_write_enable = 1'b0;
  logic [THRESH_W-1:0] cfg_write_data   = '0;
  logic                in_valid         = 1'b0;
  logic                in_stall;
  logic [ADDR_W-1:0]   fetch_address    = '0;
  logic [OPCODE_W-1:0] memory_word      = '0;
  logic                out_valid;
  logic                out_stall        = 1'b0;
  logic [OPCODE_W-1:0] instruction;
  logic [CYCLES_W-1:0] cycle_estimate;
  logic                hit;
  logic                was_hot;
  logic                address_error;

  // The request on the input port carries a flag that tells the monitor whether its
  // expected result was typed into the table. These change together with the payload.
  bit            req_pinned        = 1'b0;
  fetch_result_t req_pinned_result = '0;

  // Predictor copy of the cache lines and of the threshold register.
  bit                  line_present [LINES];
  logic [TAG_W-1:0]    line_tag_copy [LINES];
  logic [OPCODE_W-1:0] line_word [LINES];
  logic [USES_W-1:0]   line_count [LINES];
  logic [CYCLES_W-1:0] line_cost [LINES];
  logic [THRESH_W-1:0] hot_limit = HOT_THRESHOLD_RESET;

  fetch_result_t expected_fetches[$];
  table_row_t    directed_rows[$];
  int unsigned   mismatch_count = 0;
  int unsigned   cycle_count    = 0;

  decoded_instruction_cache #(
    .ENTRIES(LINES)
  ) DUT (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_enable (cfg_write_enable),
    .cfg_write_data   (cfg_write_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .fetch_address    (fetch_address),
    .memory_word      (memory_word),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .instruction      (instruction),
    .cycle_estimate   (cycle_estimate),
    .hit              (hit),
    .was_hot          (was_hot),
    .address_error    (address_error)
  );

  always #5 clk = ~clk;

  // Cycle cost from the top nibble of the opcode. The move group depends on the low nibble.
  function automatic logic [CYCLES_W-1:0] estimate_cycles(input logic [OPCODE_W-1:0] word);
    logic [3:0] top;
    top = word[OPCODE_W-1 -: 4];
    if (top == NIB_GROUP_F) return CYC_THREE;
    if (top == NIB_MOVE_GROUP) return (word[3:0] <= MOVE_SHORT_MAX) ? CYC_TWO : CYC_ONE;
    if (top == NIB_BRANCH_LIKE || top == NIB_GROUP_8 || top == NIB_GROUP_A ||
        top == NIB_GROUP_B) return CYC_TWO;
    return CYC_ONE;
  endfunction

  // Works out the result of one accepted fetch request and updates the line copy.
  // The line index is the halfword address modulo LINES; the rest of it is the tag.
  function automatic fetch_result_t predict_fetch(input logic [ADDR_W-1:0] addr,
                                                  input logic [OPCODE_W-1:0] word);
    fetch_result_t       res;
    logic [ADDR_W-2:0]   half;
    logic [IDX_W-1:0]    idx;
    logic [TAG_W-1:0]    tag;
    res  = '0;
    half = addr[ADDR_W-1:1];
    idx  = half[IDX_W-1:0];
    tag  = half[ADDR_W-2:IDX_W];
    if (addr[0]) begin
      // Odd address: flagged, nothing else reported, no line touched.
      res.address_error = 1'b1;
    end else if (line_present[idx] && line_tag_copy[idx] == tag) begin
      res.instruction    = line_word[idx];
      res.cycle_estimate = line_cost[idx];
      res.hit            = 1'b1;
      res.was_hot        = (line_count[idx] > hot_limit);
      // The use count saturates at its top value.
      if (line_count[idx] != USES_MAX) line_count[idx] = line_count[idx] + 1'b1;
    end else begin
      line_present[idx]  = 1'b1;
      line_tag_copy[idx] = tag;
      line_word[idx]     = word;
      line_count[idx]    = USES_FIRST;
      line_cost[idx]     = estimate_cycles(word);
      res.instruction    = word;
      res.cycle_estimate = line_cost[idx];
    end
    return res;
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatch_count < PRINT_LIMIT) begin
      $display("%0t ns: mismatch on %s: got %h, expected %h", $time, field, got, want);
    end
    mismatch_count++;
  endtask

  task automatic compare_fetch(input fetch_result_t got, input fetch_result_t want);
    if (got.instruction !== want.instruction)
      report_mismatch("instruction", 32'(got.instruction), 32'(want.instruction));
    if (got.cycle_estimate !== want.cycle_estimate)
      report_mismatch("cycle_estimate", 32'(got.cycle_estimate), 32'(want.cycle_estimate));
    if (got.hit !== want.hit)
      report_mismatch("hit", 32'(got.hit), 32'(want.hit));
    if (got.was_hot !== want.was_hot)
      report_mismatch("was_hot", 32'(got.was_hot), 32'(want.was_hot));
    if (got.address_error !== want.address_error)
      report_mismatch("address_error", 32'(got.address_error), 32'(want.address_error));
  endtask

  // Monitor. Everything is sampled at the rising edge, where the testbench inputs have been
  // stable since the falling edge and the block's registered outputs still hold old values.
  // A request's result leaves only after it has passed the lookup stage and the output
  // register, so checking before predicting in the same edge keeps the queue in order.
  always @(posedge clk) begin
    fetch_result_t got;
    fetch_result_t predicted;
    cycle_count++;
    if (!rst) begin
      if (cfg_write_enable) hot_limit = cfg_write_data;
      if (out_valid && !out_stall) begin
        got.instruction    = instruction;
        got.cycle_estimate = cycle_estimate;
        got.hit            = hit;
        got.was_hot        = was_hot;
        got.address_error  = address_error;
        if (expected_fetches.size() == 0) begin
          report_mismatch("result with no request waiting", 32'(got), '0);
        end else begin
          compare_fetch(got, expected_fetches.pop_front());
        end
      end
      if (in_valid && !in_stall) begin
        // The predictor always runs so that its line copy tracks the block.
        predicted = predict_fetch(fetch_address, memory_word);
        expected_fetches.push_back(req_pinned ? req_pinned_result : predicted);
      end
    end
  end

  // The receiver stalls in runs: mostly short ones, now and then a long one, and between
  // them free stretches that are sometimes long enough to let the pipeline run flat out.
  initial begin
    int unsigned free_run;
    int unsigned hold;
    forever begin
      free_run = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 8);
      repeat (free_run) begin
        @(negedge clk);
        out_stall <= 1'b0;
      end
      hold = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      repeat (hold) begin
        @(negedge clk);
        out_stall <= 1'b1;
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("decoded_instruction_cache_tb: FAIL");
    $finish;
  end

  function automatic void add_row(input logic [ADDR_W-1:0] addr, input logic [OPCODE_W-1:0] word,
                                  input bit pinned, input logic [OPCODE_W-1:0] instr,
                                  input logic [CYCLES_W-1:0] cyc, input logic is_hit,
                                  input logic hot, input logic err);
    table_row_t row;
    row.addr                  = addr;
    row.word                  = word;
    row.pinned                = pinned;
    row.result.instruction    = instr;
    row.result.cycle_estimate = cyc;
    row.result.hit            = is_hit;
    row.result.was_hot        = hot;
    row.result.address_error  = err;
    directed_rows.push_back(row);
  endfunction

  // Presents one request at the falling edge and holds it until an edge accepts it.
  // in_valid stays high on return so that a back-to-back request needs no second write.
  task automatic send_fetch(input logic [ADDR_W-1:0] addr, input logic [OPCODE_W-1:0] word,
                            input bit pinned, input fetch_result_t pinned_result);
    @(negedge clk);
    in_valid          <= 1'b1;
    fetch_address     <= addr;
    memory_word       <= word;
    req_pinned        <= pinned;
    req_pinned_result <= pinned_result;
    do @(posedge clk); while (in_stall !== 1'b0);
  endtask

  task automatic idle_gap(input int unsigned cycles);
    repeat (cycles) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  // Mostly back-to-back requests or short gaps, with a rare long one.
  function automatic int unsigned pick_gap(input bit quiet);
    int unsigned roll;
    if (quiet) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Waits until the block has nothing in flight; write_threshold uses it before writing the threshold register.
  task automatic drain_requests();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_fetches.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [THRESH_W-1:0] value);
    drain_requests();
    @(negedge clk);
    cfg_write_enable <= 1'b1;
    cfg_write_data   <= value;
    @(negedge clk);
    cfg_write_enable <= 1'b0;
  endtask

  initial begin
    logic [THRESH_W-1:0] phase_limit [PHASES];
    bit                  phase_quiet [PHASES];
    bit                  phase_saturate [PHASES];
    logic [ADDR_W-1:0]   pool [POOL_SIZE];
    logic [IDX_W-1:0]    hot_idx [HOT_INDEXES];
    logic [TAG_W-1:0]    tag;
    logic [ADDR_W-1:0]   addr;
    int unsigned         sent;
    int unsigned         burst;
    int unsigned         roll;
    bit                  same_addr;

    // Directed table, written for the reset threshold of 20. Line 0 is filled, hit, then
    // evicted by an address with the same index and another tag, then refilled.
    add_row(32'h0000_0000, 16'h0000, 1, 16'h0000, CYC_ONE, 0, 0, 0);
    add_row(32'h0000_0000, 16'hFFFF, 1, 16'h0000, CYC_ONE, 1, 0, 0);
    add_row(32'h0000_0001, 16'hFFFF, 1, 16'h0000, '0, 0, 0, 1);
    add_row(32'hFFFF_FFFF, 16'h1234, 1, 16'h0000, '0, 0, 0, 1);
    add_row(32'hFFFF_FFFE, 16'hF123, 1, 16'hF123, CYC_THREE, 0, 0, 0);
    add_row(32'hFFFF_FFFE, 16'h0000, 1, 16'hF123, CYC_THREE, 1, 0, 0);
    // Move group: the low nibble decides between CYC_TWO and CYC_ONE.
    add_row(32'h0000_0010, 16'h6003, 1, 16'h6003, CYC_TWO, 0, 0, 0);
    add_row(32'h0000_0012, 16'h6004, 1, 16'h6004, CYC_ONE, 0, 0, 0);
    add_row(32'h0000_0014, 16'h6000, 1, 16'h6000, CYC_TWO, 0, 0, 0);
    add_row(32'h0000_0016, 16'h600F, 1, 16'h600F, CYC_ONE, 0, 0, 0);
    add_row(32'h0000_0018, 16'h2ABC, 1, 16'h2ABC, CYC_TWO, 0, 0, 0);
    add_row(32'h0000_001A, 16'h8001, 1, 16'h8001, CYC_TWO, 0, 0, 0);
    add_row(32'h0000_001C, 16'hA5A5, 1, 16'hA5A5, CYC_TWO, 0, 0, 0);
    add_row(32'h0000_001E, 16'hB000, 1, 16'hB000, CYC_TWO, 0, 0, 0);
    add_row(32'h0000_0020, 16'h1234, 1, 16'h1234, CYC_ONE, 0, 0, 0);
    add_row(32'h0000_0022, 16'hC0DE, 1, 16'hC0DE, CYC_ONE, 0, 0, 0);
    add_row(32'h0000_0024, 16'h7FFF, 1, 16'h7FFF, CYC_ONE, 0, 0, 0);
    add_row(32'h0000_0400, 16'h5555, 1, 16'h5555, CYC_ONE, 0, 0, 0);
    add_row(32'h0000_0000, 16'hAAAA, 1, 16'hAAAA, CYC_TWO, 0, 0, 0);
    add_row(32'h0000_0000, 16'h0000, 1, 16'hAAAA, CYC_TWO, 1, 0, 0);
    add_row(32'h0000_0010, 16'hFFFF, 0, '0, '0, 0, 0, 0);
    add_row(32'hAAAA_AAAA, 16'h5555, 1, 16'h5555, CYC_ONE, 0, 0, 0);
    add_row(32'h5555_5554, 16'hAAAA, 1, 16'hAAAA, CYC_TWO, 0, 0, 0);
    add_row(32'h0000_0401, 16'h0001, 1, 16'h0000, '0, 0, 0, 1);

    // Thresholds per phase: both extremes, the reset value, a random one and the values
    // next to the extremes. A long run on one line saturates its use count where the
    // threshold lets that show up as a hot hit.
    phase_limit[0] = 8'd0;   phase_quiet[0] = 0; phase_saturate[0] = 1;
    phase_limit[1] = 8'd255; phase_quiet[1] = 0; phase_saturate[1] = 0;
    phase_limit[2] = 8'd20;  phase_quiet[2] = 1; phase_saturate[2] = 0;
    phase_limit[3] = THRESH_W'($urandom_range(2, 253));
    phase_quiet[3] = 0; phase_saturate[3] = 0;
    phase_limit[4] = 8'd1;   phase_quiet[4] = 0; phase_saturate[4] = 0;
    phase_limit[5] = 8'd254; phase_quiet[5] = 0; phase_saturate[5] = 1;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // The block clears its lines after reset with in_stall high; the first request simply
    // waits on the handshake.
    foreach (directed_rows[i]) begin
      send_fetch(directed_rows[i].addr, directed_rows[i].word, directed_rows[i].pinned,
                 directed_rows[i].result);
      idle_gap(pick_gap(0));
    end

    for (int p = 0; p < PHASES; p++) begin
      write_threshold(phase_limit[p]);
      // A small working set whose lines share a few indexes, so that hits, evictions and
      // refills all come often.
      foreach (hot_idx[i]) hot_idx[i] = IDX_W'($urandom_range(0, LINES - 1));
      foreach (pool[i]) begin
        tag     = TAG_W'($urandom());
        pool[i] = {tag, hot_idx[$urandom_range(0, HOT_INDEXES - 1)], 1'b0};
      end
      sent = 0;
      if (phase_saturate[p]) begin
        repeat (280) begin
          send_fetch(pool[0], 16'($urandom()), 0, '0);
          idle_gap(pick_gap(phase_quiet[p]));
          sent++;
        end
      end
      while (sent < PHASE_ITEMS) begin
        roll      = $urandom_range(0, 99);
        same_addr = 0;
        addr      = pool[$urandom_range(0, POOL_SIZE - 1)];
        if (roll < 45) begin
          burst = $urandom_range(1, 8);
        end else if (roll < 75) begin
          // Repeated requests to one line drive its use count up, past low thresholds.
          same_addr = 1;
          burst     = $urandom_range(4, 40);
        end else if (roll < 88) begin
          burst = 1;
          addr  = $urandom();
        end else begin
          burst = 1;
          addr  = addr | 32'h1;
        end
        repeat (burst) begin
          if (!same_addr && roll < 45) addr = pool[$urandom_range(0, POOL_SIZE - 1)];
          send_fetch(addr, 16'($urandom()), 0, '0);
          idle_gap(pick_gap(phase_quiet[p]));
          sent++;
        end
      end
    end

    drain_requests();
    if (mismatch_count == 0) begin
      $display("decoded_instruction_cache_tb: PASS");
    end else begin
      $display("decoded_instruction_cache_tb: FAIL");
    end
    $finish;
  end

endmodule

[files.f]
rtl/dic_pkg.sv
rtl/dic_line_ram.sv
rtl/dic_lookup.sv
rtl/decoded_instruction_cache.sv
tb/decoded_instruction_cache_tb.sv
